FILE: sv/rtrlh_pkg.sv
// ----------------------------------------------------------------------------
// rtrlh_pkg
// Shared types, sizes and helper functions of the ready-to-run latency
// histogram monitor.
// ----------------------------------------------------------------------------
package rtrlh_pkg;

    // Ring of task slots; the depth must be a power of two.
    localparam int RING_DEPTH = 1024;
    localparam int SLOT_W     = $clog2(RING_DEPTH);

    // Histogram bins per path and the histogram memory covering both paths.
    localparam int BIN_COUNT  = 64;
    localparam int BIN_W      = $clog2(BIN_COUNT);
    localparam int HIST_DEPTH = 2 * BIN_COUNT;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);

    // The clearing sweep after reset covers the larger of the two memories.
    localparam int CLR_DEPTH  = (RING_DEPTH > HIST_DEPTH) ? RING_DEPTH : HIST_DEPTH;
    localparam int CLR_W      = $clog2(CLR_DEPTH);

    localparam int TAG_W      = 16;
    localparam int DATA_W     = 64;

    // Request codes.
    localparam logic [1:0] REQ_READY    = 2'd0;
    localparam logic [1:0] REQ_RUNNABLE = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;

    typedef struct packed {
        logic                valid;
        logic [TAG_W-1:0]    tag;
        logic [DATA_W-1:0]   time_ns;
    } t_ring_entry;

    localparam int RING_W = $bits(t_ring_entry);

    // Statistics update request from the control FSM.
    typedef struct packed {
        logic                upd;
        logic                path;
        logic [DATA_W-1:0]   lat;
    } t_stat_upd;

    // Statistics of one path.
    typedef struct packed {
        logic [DATA_W-1:0]   count;
        logic [DATA_W-1:0]   sum;
        logic [DATA_W-1:0]   max;
    } t_path_stats;

    // Bit width of a 64-bit value: a leading-one search done per byte, then
    // a pick of the highest nonzero byte.
    function automatic logic [6:0] bit_width64(input logic [63:0] v);
        logic [3:0] lw [8];
        logic [6:0] w;
        for (int g = 0; g < 8; g++) begin
            lw[g] = 4'd0;
            for (int k = 0; k < 8; k++) begin
                if (v[g*8 + k]) begin
                    lw[g] = 4'(k + 1);
                end
            end
        end
        w = 7'd0;
        for (int g = 0; g < 8; g++) begin
            if (lw[g] != 4'd0) begin
                w = 7'(g * 8) + 7'(lw[g]);
            end
        end
        return w;
    endfunction

    // Histogram bin of a latency, saturated at the last bin.
    function automatic logic [BIN_W-1:0] bin_of(input logic [63:0] lat);
        logic [6:0] b;
        b = bit_width64(lat);
        if (32'(b) >= 32'(BIN_COUNT)) begin
            return BIN_W'(BIN_COUNT - 1);
        end
        return BIN_W'(b);
    endfunction

    // Histogram address of a path and bin.
    function automatic logic [HIST_AW-1:0] hist_addr(input logic path,
                                                     input logic [BIN_W-1:0] bin);
        return HIST_AW'(32'(path) * BIN_COUNT + 32'(bin));
    endfunction

endpackage

FILE: sv/rtrlh_ram.sv
// ----------------------------------------------------------------------------
// rtrlh_ram
// Simple dual-port synchronous RAM with one write port and one registered
// read port.
// ----------------------------------------------------------------------------
module rtrlh_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: sv/rtrlh_stats.sv
// ----------------------------------------------------------------------------
// rtrlh_stats
// Per-path sample count, latency sum and latency maximum, with a read mux
// for the path of the current transaction.
// ----------------------------------------------------------------------------
module rtrlh_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtrlh_pkg::t_stat_upd i_upd,
    input  logic                 i_rd_path,
    output rtrlh_pkg::t_path_stats o_stats
);

    import rtrlh_pkg::*;

    logic [DATA_W-1:0] r_count [2];
    logic [DATA_W-1:0] r_sum   [2];
    logic [DATA_W-1:0] r_max   [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_count[p] <= '0;
                r_sum[p]   <= '0;
                r_max[p]   <= '0;
            end
        end else if (i_upd.upd) begin
            // Count and sum wrap modulo 2^64.
            r_count[i_upd.path] <= r_count[i_upd.path] + DATA_W'(1);
            r_sum[i_upd.path]   <= r_sum[i_upd.path] + i_upd.lat;
            if (i_upd.lat > r_max[i_upd.path]) begin
                r_max[i_upd.path] <= i_upd.lat;
            end
        end
    end

    assign o_stats.count = r_count[i_rd_path];
    assign o_stats.sum   = r_sum[i_rd_path];
    assign o_stats.max   = r_max[i_rd_path];

endmodule

FILE: sv/ready_to_run_latency_histogram_top.sv
// ----------------------------------------------------------------------------
// ready_to_run_latency_histogram_top
// Ready-to-run latency monitor: slot ring of ready timestamps, per-path
// statistics and a log2 latency histogram.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on the input channel (i_in_valid / o_in_ready) and each one
// produces exactly one result transaction on the output channel
// (o_out_valid / i_out_ready). A mark-ready request stores its time and tag in
// the ring slot; a mark-runnable request with a matching tag closes the slot
// and, when the run time is not earlier than the ready time, records a sample;
// a read request returns a path's statistics and one histogram bin.
// The block works on one request at a time. A mark-runnable request that takes
// a sample passes through ring read, bin search, histogram read, histogram
// write-back and result load before the next acceptance; every other request
// goes from the ring read straight to the result load. The sequence of ring
// and histogram memory accesses sets these steps. The result becomes valid
// at the result load step, which waits until the receiver is ready.
// After reset the block sweeps both memories, one entry per cycle, with
// o_in_ready low; statistics registers clear at once.
// The result sits in an output register. When the receiver stalls, the block
// still accepts the next request and holds its finished result until the
// output register frees up.
// ----------------------------------------------------------------------------
module ready_to_run_latency_histogram_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_task_id,
    input  logic [63:0] i_time_ns,
    input  logic        i_early_path,
    input  logic [5:0]  i_bin_select,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_sample_taken,
    output logic [63:0] o_latency_ns,
    output logic [5:0]  o_bin_index,
    output logic [63:0] o_path_count,
    output logic [63:0] o_path_sum_ns,
    output logic [63:0] o_path_max_ns,
    output logic [63:0] o_bin_count
);

    import rtrlh_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_LOOK  = 6'b000100,
        S_BIN   = 6'b001000,
        S_HIST  = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CLR_W-1:0]  r_clr_idx;

    // Transaction being worked on.
    logic [1:0]        r_req;
    logic [TAG_W-1:0]  r_tag;
    logic [DATA_W-1:0] r_time;
    logic              r_path;
    logic [5:0]        r_sel;
    logic              r_take;
    logic [DATA_W-1:0] r_lat;
    logic [BIN_W-1:0]  r_bin;
    logic [DATA_W-1:0] r_bin_cnt;

    logic              in_acc;
    logic              out_free;
    logic [SLOT_W-1:0] slot;
    logic              clr_ring;
    logic              clr_hist;

    logic              ring_we, ring_re;
    logic [SLOT_W-1:0] ring_waddr, ring_raddr;
    t_ring_entry       ring_wdata, ring_rdata;
    logic [RING_W-1:0] ring_rvec;

    logic               hist_we, hist_re;
    logic [HIST_AW-1:0] hist_waddr, hist_raddr;
    logic [DATA_W-1:0]  hist_wdata, hist_rdata;

    logic              hit;
    logic [BIN_W-1:0]  bin_new;
    t_stat_upd         stat_upd;
    t_path_stats       stats;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;
    assign slot       = i_task_id[SLOT_W-1:0];
    assign ring_rdata = t_ring_entry'(ring_rvec);
    assign hit        = (r_req == REQ_RUNNABLE) && ring_rdata.valid
                        && (ring_rdata.tag == r_tag);
    assign bin_new    = bin_of(r_lat);
    assign clr_ring   = (32'(r_clr_idx) < 32'(RING_DEPTH));
    assign clr_hist   = (32'(r_clr_idx) < 32'(HIST_DEPTH));

    rtrlh_ram #(
        .DEPTH (RING_DEPTH),
        .WIDTH (RING_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rvec)
    );

    rtrlh_ram #(
        .DEPTH (HIST_DEPTH),
        .WIDTH (DATA_W)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (hist_waddr),
        .i_wdata (hist_wdata),
        .i_re    (hist_re),
        .i_raddr (hist_raddr),
        .o_rdata (hist_rdata)
    );

    rtrlh_stats u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (stat_upd),
        .i_rd_path (r_path),
        .o_stats   (stats)
    );

    assign stat_upd.upd  = (r_state == S_BIN);
    assign stat_upd.path = r_path;
    assign stat_upd.lat  = r_lat;

    // Ring port: clearing sweep, mark-ready write, lookup read, tag invalidate.
    always_comb begin
        ring_we    = 1'b0;
        ring_waddr = slot;
        ring_wdata = '{valid: 1'b1, tag: i_task_id, time_ns: i_time_ns};
        ring_re    = 1'b0;
        ring_raddr = slot;
        unique case (r_state)
            S_CLEAR: begin
                ring_we    = clr_ring;
                ring_waddr = r_clr_idx[SLOT_W-1:0];
                ring_wdata = '0;
            end
            S_IDLE: begin
                ring_we = in_acc && (i_req_type == REQ_READY);
                ring_re = in_acc;
            end
            S_LOOK: begin
                ring_we    = hit;
                ring_waddr = r_tag[SLOT_W-1:0];
                ring_wdata = '{valid: 1'b0, tag: r_tag, time_ns: ring_rdata.time_ns};
            end
            default: begin
            end
        endcase
    end

    // Histogram port: clearing sweep, bin read-back, increment read and write.
    always_comb begin
        hist_we    = 1'b0;
        hist_waddr = hist_addr(r_path, r_bin);
        hist_wdata = hist_rdata + DATA_W'(1);
        hist_re    = 1'b0;
        hist_raddr = hist_addr(i_early_path, BIN_W'(i_bin_select));
        unique case (r_state)
            S_CLEAR: begin
                hist_we    = clr_hist;
                hist_waddr = r_clr_idx[HIST_AW-1:0];
                hist_wdata = '0;
            end
            S_IDLE: begin
                hist_re = in_acc && (i_req_type == REQ_READ);
            end
            S_BIN: begin
                hist_re    = 1'b1;
                hist_raddr = hist_addr(r_path, bin_new);
            end
            S_HIST: begin
                hist_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_clr_idx) == 32'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (hit && (r_time >= ring_rdata.time_ns)) begin
                    n_state = S_BIN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_BIN:  n_state = S_HIST;
            S_HIST: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + CLR_W'(1);
            end
        end
    end

    // Working registers of the transaction.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_req     <= i_req_type;
                    r_tag     <= i_task_id;
                    r_time    <= i_time_ns;
                    r_path    <= i_early_path;
                    r_sel     <= i_bin_select;
                    r_take    <= 1'b0;
                    r_bin_cnt <= '0;
                end
            end
            S_LOOK: begin
                r_lat  <= r_time - ring_rdata.time_ns;
                r_take <= hit && (r_time >= ring_rdata.time_ns);
                if ((r_req == REQ_READ) && (32'(r_sel) < 32'(BIN_COUNT))) begin
                    r_bin_cnt <= hist_rdata;
                end
            end
            S_BIN: begin
                r_bin <= bin_new;
            end
            S_HIST: begin
                r_bin_cnt <= hist_wdata;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            o_sample_taken <= r_take;
            o_latency_ns   <= r_take ? r_lat : '0;
            if (r_take) begin
                o_bin_index <= 6'(32'(r_bin));
            end else if (r_req == REQ_READ) begin
                o_bin_index <= r_sel;
            end else begin
                o_bin_index <= '0;
            end
            o_path_count  <= stats.count;
            o_path_sum_ns <= stats.sum;
            o_path_max_ns <= stats.max;
            o_bin_count   <= r_bin_cnt;
        end
    end

endmodule

FILE: dv/ready_to_run_latency_histogram_top_tb.sv
// ----------------------------------------------------------------------------
// ready_to_run_latency_histogram_top_tb
// Self-checking bench for the ready-to-run latency monitor. A directed table
// walks reset values, tag mismatch, run before ready, zero and full-width
// latencies and the unused request code. Random ready/runnable pairs with
// latencies of every bit width follow, mixed with reads and stray requests.
// Every result transaction is compared with a local model of the ring, the path
// statistics and the histogram, or with the expected result a table row gives.
// ----------------------------------------------------------------------------
module ready_to_run_latency_histogram_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import rtrlh_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam int         RAND_ITEMS     = 1450;
    localparam int         PAUSE_AT       = 700;
    localparam int         WATCHDOG_LIMIT = 6000;
    localparam int         DRAIN_CYCLES   = 16;
    localparam logic [63:0] ALL_ONES      = '1;

    typedef struct packed {
        logic [1:0]  req;
        logic [15:0] task_id;
        logic [63:0] stamp;
        logic        early;
        logic [5:0]  bin_sel;
    } t_lat_req;

    typedef struct packed {
        logic        taken;
        logic [63:0] latency;
        logic [5:0]  bin;
        logic [63:0] count;
        logic [63:0] sum;
        logic [63:0] peak;
        logic [63:0] bin_cnt;
    } t_lat_res;

    typedef struct packed {
        t_lat_req rq;
        logic     typed;
        t_lat_res res;
    } t_dir_row;

    typedef struct packed {
        logic [15:0] tid;
        logic [63:0] run_at;
    } t_open_task;

    localparam t_lat_res ZERO_RES = '0;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [15:0] i_task_id;
    logic [63:0] i_time_ns;
    logic        i_early_path;
    logic [5:0]  i_bin_select;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_sample_taken;
    logic [63:0] o_latency_ns;
    logic [5:0]  o_bin_index;
    logic [63:0] o_path_count;
    logic [63:0] o_path_sum_ns;
    logic [63:0] o_path_max_ns;
    logic [63:0] o_bin_count;

    ready_to_run_latency_histogram_top dut (.*);

    // Model state.
    logic [63:0] ring_stamp [RING_DEPTH];
    logic [15:0] ring_tag   [RING_DEPTH];
    logic        ring_live  [RING_DEPTH];
    logic [63:0] stat_count [2];
    logic [63:0] stat_sum   [2];
    logic [63:0] stat_peak  [2];
    logic [63:0] hist_cnt   [2 * BIN_COUNT];

    t_lat_res    exp_q [$];
    t_dir_row    dir_rows [$];
    t_open_task  open_tasks [$];

    logic        drv_typed;
    t_lat_res    drv_exp;
    logic        calm;
    int          stall_left  = 0;
    int          in_flight   = 0;
    int          idle_cycles = 0;
    int          fail_count  = 0;
    int          samples_normal = 0;
    int          samples_early  = 0;
    int          reads_done     = 0;
    int          saturated      = 0;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic int lat_width(logic [63:0] v);
        int w;
        w = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                w = i + 1;
            end
        end
        return w;
    endfunction

    // Applies one request to the model and returns the result it must give.
    function automatic t_lat_res predict_result(t_lat_req rq);
        t_lat_res          r;
        logic [SLOT_W-1:0] slot;
        logic [63:0]       lat;
        int                p;
        int                b;
        r    = '0;
        slot = rq.task_id[SLOT_W-1:0];
        p    = int'(rq.early);
        case (rq.req)
            REQ_READY: begin
                ring_stamp[slot] = rq.stamp;
                ring_tag[slot]   = rq.task_id;
                ring_live[slot]  = 1'b1;
            end
            REQ_RUNNABLE: begin
                if (ring_live[slot] && ring_tag[slot] == rq.task_id) begin
                    ring_live[slot] = 1'b0;
                    if (rq.stamp >= ring_stamp[slot]) begin
                        lat = rq.stamp - ring_stamp[slot];
                        stat_count[p] += 64'd1;
                        stat_sum[p]   += lat;
                        if (lat > stat_peak[p]) begin
                            stat_peak[p] = lat;
                        end
                        b = lat_width(lat);
                        if (b >= BIN_COUNT) begin
                            b = BIN_COUNT - 1;
                        end
                        hist_cnt[p * BIN_COUNT + b] += 64'd1;
                        r.taken   = 1'b1;
                        r.latency = lat;
                        r.bin     = 6'(b);
                        r.bin_cnt = hist_cnt[p * BIN_COUNT + b];
                    end
                end
            end
            REQ_READ: begin
                r.bin = rq.bin_sel;
                if (int'(rq.bin_sel) < BIN_COUNT) begin
                    r.bin_cnt = hist_cnt[p * BIN_COUNT + int'(rq.bin_sel)];
                end
            end
            default: begin
            end
        endcase
        r.count = stat_count[p];
        r.sum   = stat_sum[p];
        r.peak  = stat_peak[p];
        return r;
    endfunction

    function automatic void check_result(t_lat_res want, t_lat_res got);
        logic [63:0] w [7];
        logic [63:0] g [7];
        string       nm [7];
        nm = '{"sample_taken", "latency_ns", "bin_index", "path_count",
               "path_sum_ns", "path_max_ns", "bin_count"};
        w = '{64'(want.taken), want.latency, 64'(want.bin), want.count,
              want.sum, want.peak, want.bin_cnt};
        g = '{64'(got.taken), got.latency, 64'(got.bin), got.count,
              got.sum, got.peak, got.bin_cnt};
        for (int i = 0; i < 7; i++) begin
            if (w[i] !== g[i]) begin
                $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
                         $time, nm[i], w[i], g[i]);
                fail_count++;
            end
        end
    endfunction

    function automatic t_dir_row mk_row(logic [1:0] req, logic [15:0] tid,
                                        logic [63:0] stamp, logic early,
                                        logic [5:0] sel, logic typed,
                                        t_lat_res res);
        t_dir_row d;
        d.rq    = {req, tid, stamp, early, sel};
        d.typed = typed;
        d.res   = res;
        return d;
    endfunction

    // Mostly well-formed ready/runnable pairs; the rest are reads, stray
    // runnables, slot aliases and the unused request code.
    function automatic t_lat_req next_random_req();
        t_lat_req   rq;
        t_open_task ot;
        int         pick;
        int         w;
        int         idx;
        logic [63:0] lat;
        logic [63:0] at;
        rq.req     = REQ_READ;
        rq.task_id = 16'($urandom);
        rq.stamp   = {$urandom, $urandom};
        rq.early   = 1'($urandom);
        rq.bin_sel = 6'($urandom);
        pick = $urandom_range(0, 99);
        if (open_tasks.size() >= 12 && pick < 40) begin
            pick = 40;
        end
        if (pick < 35) begin
            rq.req = REQ_READY;
            if (open_tasks.size() != 0 && $urandom_range(0, 9) == 0) begin
                // Same slot as an open task, different generation tag.
                rq.task_id = open_tasks[0].tid ^ (16'($urandom_range(1, 63)) << SLOT_W);
            end
            w   = $urandom_range(0, 64);
            lat = (w == 0) ? 64'd0
                           : (({$urandom, $urandom} >> (64 - w)) | (64'd1 << (w - 1)));
            at  = {$urandom, $urandom} >> $urandom_range(0, 63);
            rq.stamp  = at;
            ot.tid    = rq.task_id;
            ot.run_at = ($urandom_range(0, 9) == 0) ? at - 64'($urandom_range(1, 1000))
                                                    : at + lat;
            open_tasks.push_back(ot);
        end else if (pick < 75 && open_tasks.size() != 0) begin
            idx        = $urandom_range(0, open_tasks.size() - 1);
            rq.req     = REQ_RUNNABLE;
            rq.task_id = open_tasks[idx].tid;
            rq.stamp   = open_tasks[idx].run_at;
            open_tasks.delete(idx);
        end else if (pick < 82) begin
            rq.req = REQ_RUNNABLE;
        end else if (pick < 95) begin
            rq.req = REQ_READ;
        end else begin
            rq.req = REQ_UNUSED;
        end
        return rq;
    endfunction

    // Receiver: random stall bursts, none while calm.
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left  <= 0;
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Scoreboard and watchdog.
    always @(posedge i_clk) begin
        t_lat_res got;
        t_lat_res model;
        t_lat_req cur;
        logic     acc_in;
        logic     acc_out;
        if (i_rst_n) begin
            acc_in  = i_in_valid && o_in_ready;
            acc_out = o_out_valid && i_out_ready;
            if (acc_out) begin
                got = {o_sample_taken, o_latency_ns, o_bin_index, o_path_count,
                       o_path_sum_ns, o_path_max_ns, o_bin_count};
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%h",
                             $time, got);
                    fail_count++;
                end else begin
                    check_result(exp_q.pop_front(), got);
                end
            end
            if (acc_in) begin
                cur   = {i_req_type, i_task_id, i_time_ns, i_early_path, i_bin_select};
                model = predict_result(cur);
                exp_q.push_back(drv_typed ? drv_exp : model);
                if (model.taken) begin
                    if (cur.early) samples_early++;
                    else samples_normal++;
                    if (model.bin == 6'(BIN_COUNT - 1)) saturated++;
                end
                if (cur.req == REQ_READ) reads_done++;
            end
            in_flight <= in_flight + int'(acc_in) - int'(acc_out);
            if (acc_in || acc_out) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // Sender.
    initial begin
        t_dir_row dr;
        int       k;
        int       useful;
        logic     calm_now;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= REQ_READY;
        i_task_id    <= '0;
        i_time_ns    <= '0;
        i_early_path <= 1'b0;
        i_bin_select <= '0;
        drv_typed    <= 1'b0;
        drv_exp      <= ZERO_RES;
        calm         <= 1'b0;
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_stamp[i] = '0;
            ring_tag[i]   = '0;
            ring_live[i]  = 1'b0;
        end
        for (int i = 0; i < 2 * BIN_COUNT; i++) begin
            hist_cnt[i] = '0;
        end
        for (int i = 0; i < 2; i++) begin
            stat_count[i] = '0;
            stat_sum[i]   = '0;
            stat_peak[i]  = '0;
        end

        dir_rows.push_back(mk_row(REQ_READ, 16'd0, 64'd0, 1'b0, 6'd0, 1'b1, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READ, 16'hFFFF, ALL_ONES, 1'b1, 6'd63, 1'b1,
                                  {1'b0, 64'd0, 6'd63, 64'd0, 64'd0, 64'd0, 64'd0}));
        // Runnable on a slot that was never marked ready.
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd5, 64'd100, 1'b0, 6'd0, 1'b1, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READY, 16'd5, 64'd100, 1'b0, 6'd63, 1'b1, ZERO_RES));
        // Same slot, other generation: no sample and the slot stays open.
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd1029, 64'd200, 1'b0, 6'd0, 1'b1,
                                  ZERO_RES));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd5, 64'd100, 1'b0, 6'd0, 1'b1,
                                  {1'b1, 64'd0, 6'd0, 64'd1, 64'd0, 64'd0, 64'd1}));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd5, 64'd300, 1'b0, 6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READY, 16'hFFFF, ALL_ONES, 1'b1, 6'd0, 1'b1, ZERO_RES));
        // Run before ready closes the slot without a sample.
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'hFFFF, 64'd0, 1'b1, 6'd0, 1'b1, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'hFFFF, ALL_ONES, 1'b1, 6'd0, 1'b0,
                                  ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READY, 16'd0, 64'd0, 1'b0, 6'd0, 1'b0, ZERO_RES));
        // Full 64-bit latency lands in the saturated last bin.
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd0, ALL_ONES, 1'b1, 6'd0, 1'b1,
                                  {1'b1, ALL_ONES, 6'd63, 64'd1, ALL_ONES, ALL_ONES, 64'd1}));
        dir_rows.push_back(mk_row(REQ_READY, 16'h8000, 64'd1, 1'b0, 6'd0, 1'b0, ZERO_RES));
        // The sum wraps past 2^64 here.
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'h8000, 64'h8000_0000_0000_0000, 1'b1,
                                  6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READY, 16'd3, 64'd10, 1'b0, 6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd3, 64'd11, 1'b0, 6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READ, 16'd0, 64'd0, 1'b1, 6'd63, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READ, 16'd0, 64'd0, 1'b0, 6'd1, 1'b0, ZERO_RES));
        // The unused code must not open slot 77.
        dir_rows.push_back(mk_row(REQ_UNUSED, 16'd77, 64'd123, 1'b0, 6'd7, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd77, 64'd200, 1'b0, 6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READY, 16'd2, 64'd5, 1'b1, 6'd0, 1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_RUNNABLE, 16'd2, 64'd5 + (64'd1 << 40), 1'b1, 6'd0,
                                  1'b0, ZERO_RES));
        dir_rows.push_back(mk_row(REQ_READ, 16'd0, 64'd0, 1'b1, 6'd41, 1'b0, ZERO_RES));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        k      = 0;
        useful = 0;
        while (k < dir_rows.size() || useful < RAND_ITEMS) begin
            if (k < dir_rows.size()) begin
                dr = dir_rows[k];
            end else begin
                dr.rq    = next_random_req();
                dr.typed = 1'b0;
                dr.res   = ZERO_RES;
                if (dr.rq.req != REQ_UNUSED) useful++;
            end
            calm_now = (k >= 400 && k < 480) || (useful >= RAND_ITEMS - 150);
            calm <= calm_now;
            if (k == PAUSE_AT) begin
                // Hold off until the block has delivered everything.
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (in_flight != 0) @(posedge i_clk);
            end else if (!calm_now && $urandom_range(0, 5) == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_in_valid   <= 1'b1;
            i_req_type   <= dr.rq.req;
            i_task_id    <= dr.rq.task_id;
            i_time_ns    <= dr.rq.stamp;
            i_early_path <= dr.rq.early;
            i_bin_select <= dr.rq.bin_sel;
            drv_typed    <= dr.typed;
            drv_exp      <= dr.res;
            @(posedge i_clk);
            while (!o_in_ready) @(posedge i_clk);
            k++;
        end
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (in_flight != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (exp_q.size() != 0) begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, exp_q.size());
            fail_count++;
        end
        $display("Ran %0d requests: %0d normal-path and %0d early-path samples,",
                 k, samples_normal, samples_early);
        $display("%0d of them in the saturated bin, and %0d statistics reads.",
                 saturated, reads_done);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
